// ===== design/lfrc_pkg.sv =====
`timescale 1ns / 1ps
package lfrc_pkg;

    typedef enum logic [2:0] {
        MD_RESET  = 3'd0,
        MD_IDLE   = 3'd1,
        MD_FWD    = 3'd2,
        MD_REV    = 3'd3,
        MD_RECOV  = 3'd4,
        MD_MANUAL = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        PH_NONE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_SPIN  = 3'd2,
        PH_SEEK  = 3'd3,
        PH_DWELL = 3'd4,
        PH_PAUSE = 3'd5
    } t_phase;

    localparam logic [2:0]  FUNC_TICK   = 3'd0;
    localparam logic [2:0]  FUNC_MANUAL = 3'd6;

    localparam logic [2:0]  REG_PROP    = 3'd0;
    localparam logic [2:0]  REG_DERIV   = 3'd1;
    localparam logic [2:0]  REG_BASE    = 3'd2;
    localparam logic [2:0]  REG_MAX     = 3'd3;
    localparam logic [2:0]  REG_TURN    = 3'd4;
    localparam logic [2:0]  REG_REVERSE = 3'd5;
    localparam logic [2:0]  REG_OBST    = 3'd6;
    localparam logic [2:0]  REG_TARGET  = 3'd7;

    localparam logic [31:0] PRE_TURN_MS  = 32'd150;
    localparam logic [31:0] SPIN_MS      = 32'd350;
    localparam logic [31:0] DEBOUNCE_MS  = 32'd1500;
    localparam logic [31:0] DWELL_FWD_MS = 32'd1500;
    localparam logic [31:0] DWELL_RET_MS = 32'd1000;
    localparam logic [31:0] PAUSE_MS     = 32'd200;
    localparam logic [31:0] HOLD_MS      = 32'd2000;
    localparam logic [11:0] SETTLE_LIMIT = 12'd51;
    localparam logic [12:0] NEAR_LIMIT   = 13'd20;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
        logic [9:0]  cruise_spd;
        logic [9:0]  top_spd;
        logic [9:0]  spin_spd;
        logic [9:0]  back_spd;
        logic [12:0] obstacle_limit;
        logic [1:0]  target_slot;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [11:0] line_error;
        logic               right_branch;
        logic               left_branch;
        logic               cross_mark;
        logic               dest_mark;
        logic [12:0]        range_tenths;
        logic signed [10:0] manual_left;
        logic signed [10:0] manual_right;
        logic [9:0]         elapsed_ms;
    } t_req;

    typedef struct packed {
        logic signed [10:0] left_speed;
        logic signed [10:0] right_speed;
        logic [2:0]         mode_now;
        logic [1:0]         stage_now;
        logic [2:0]         phase_now;
        logic               arrived;
    } t_res;

endpackage

// ===== design/lfrc_cfg.sv =====
`timescale 1ns / 1ps
module lfrc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lfrc_pkg::t_cfg    o_cfg
);
    import lfrc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= 16'd256;
            r_cfg.deriv_gain     <= 16'd0;
            r_cfg.cruise_spd     <= 10'd150;
            r_cfg.top_spd        <= 10'd255;
            r_cfg.spin_spd       <= 10'd120;
            r_cfg.back_spd       <= 10'd100;
            r_cfg.obstacle_limit <= 13'd150;
            r_cfg.target_slot    <= 2'd1;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_PROP:    r_cfg.prop_gain      <= pwdata[15:0];
                REG_DERIV:   r_cfg.deriv_gain     <= pwdata[15:0];
                REG_BASE:    r_cfg.cruise_spd     <= pwdata[9:0];
                REG_MAX:     r_cfg.top_spd        <= pwdata[9:0];
                REG_TURN:    r_cfg.spin_spd       <= pwdata[9:0];
                REG_REVERSE: r_cfg.back_spd       <= pwdata[9:0];
                REG_OBST:    r_cfg.obstacle_limit <= pwdata[12:0];
                REG_TARGET:  r_cfg.target_slot    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROP:    prdata = {16'd0, r_cfg.prop_gain};
            REG_DERIV:   prdata = {16'd0, r_cfg.deriv_gain};
            REG_BASE:    prdata = {22'd0, r_cfg.cruise_spd};
            REG_MAX:     prdata = {22'd0, r_cfg.top_spd};
            REG_TURN:    prdata = {22'd0, r_cfg.spin_spd};
            REG_REVERSE: prdata = {22'd0, r_cfg.back_spd};
            REG_OBST:    prdata = {19'd0, r_cfg.obstacle_limit};
            REG_TARGET:  prdata = {30'd0, r_cfg.target_slot};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/lfrc_core.sv =====
`timescale 1ns / 1ps
module lfrc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  lfrc_pkg::t_cfg  i_cfg,
    input  lfrc_pkg::t_req  i_req,
    output lfrc_pkg::t_res  o_res
);
    import lfrc_pkg::*;

    t_mode              r_mode, n_mode;
    t_phase             r_phase, n_phase;
    logic [1:0]         r_fwd, n_fwd, r_ret, n_ret;
    logic               r_rec, n_rec;
    logic [1:0]         r_rcnt, n_rcnt, r_lfwd, n_lfwd, r_lret, n_lret;
    logic signed [11:0] r_prev, n_prev;
    logic [31:0]        r_clock, r_stamp, n_stamp, r_hold, n_hold;
    logic [31:0]        r_until, n_until;
    logic               r_spin_r, n_spin_r;
    logic [2:0]         r_held, n_held;
    logic signed [10:0] n_left, n_right;

    logic [31:0]        clk_now;
    logic               expired, settled, obst, calm, fn_valid;
    logic signed [11:0] e, ae;
    logic signed [28:0] p_term;
    logic signed [12:0] de;
    logic signed [29:0] d_term;
    logic signed [30:0] pd_sum, pd_adj;
    logic signed [14:0] u;
    logic signed [16:0] l17, r17;
    logic signed [10:0] pd_l, pd_r, base_s, turn_s, spin_l, spin_r, man_l, man_r;

    function automatic logic signed [10:0] clamp_spd(input logic signed [16:0] v,
                                                     input logic [9:0] mx);
        if (v < 17'sd0)
            clamp_spd = 11'sd0;
        else if (v > $signed({7'd0, mx}))
            clamp_spd = $signed({1'b0, mx});
        else
            clamp_spd = v[10:0];
    endfunction

    function automatic logic [1:0] sat_inc(input logic [1:0] c);
        sat_inc = (c == 2'd3) ? 2'd3 : c + 2'd1;
    endfunction

    assign e        = i_req.line_error;
    assign ae       = e[11] ? -e : e;
    assign calm     = ($unsigned(ae) <= SETTLE_LIMIT);
    assign clk_now  = r_clock + {22'd0, i_req.elapsed_ms};
    assign expired  = ~(clk_now - r_until) >> 31 == 32'd1;
    assign settled  = (clk_now - r_stamp) > DEBOUNCE_MS;
    assign obst     = (i_req.range_tenths > NEAR_LIMIT)
                    && (i_req.range_tenths < i_cfg.obstacle_limit);
    assign fn_valid = (i_req.func != FUNC_TICK) && (i_req.func <= FUNC_MANUAL);

    // PD in Q.16, truncated toward zero
    assign p_term = e * $signed({1'b0, i_cfg.prop_gain});
    assign de     = $signed({e[11], e}) - $signed({r_prev[11], r_prev});
    assign d_term = de * $signed({1'b0, i_cfg.deriv_gain});
    assign pd_sum = $signed({{2{p_term[28]}}, p_term}) + $signed({d_term[29], d_term});
    assign pd_adj = pd_sum[30] ? pd_sum + 31'sd65535 : pd_sum;
    assign u      = pd_adj[30:16];
    assign l17    = $signed({7'd0, i_cfg.cruise_spd}) + $signed({{2{u[14]}}, u});
    assign r17    = $signed({7'd0, i_cfg.cruise_spd}) - $signed({{2{u[14]}}, u});
    assign pd_l   = clamp_spd(l17, i_cfg.top_spd);
    assign pd_r   = clamp_spd(r17, i_cfg.top_spd);

    assign base_s = $signed({1'b0, i_cfg.cruise_spd});
    assign turn_s = $signed({1'b0, i_cfg.spin_spd});
    assign spin_l = r_spin_r ? turn_s : -turn_s;
    assign spin_r = r_spin_r ? -turn_s : turn_s;
    assign man_l  = (i_req.manual_left == 11'sh400) ? -11'sd1023 : i_req.manual_left;
    assign man_r  = (i_req.manual_right == 11'sh400) ? -11'sd1023 : i_req.manual_right;

    always_comb begin
        n_mode = r_mode;   n_phase = r_phase;
        n_fwd = r_fwd;     n_ret = r_ret;     n_rec = r_rec;
        n_rcnt = r_rcnt;   n_lfwd = r_lfwd;   n_lret = r_lret;
        n_prev = r_prev;   n_stamp = r_stamp; n_hold = r_hold;
        n_until = r_until; n_spin_r = r_spin_r; n_held = r_held;
        n_left = 11'sd0;   n_right = 11'sd0;

        if (r_phase != PH_NONE) begin
            if (fn_valid) n_held = i_req.func;
            case (r_phase)
                PH_PAUSE: begin
                    if (expired) begin
                        n_phase = PH_PRE;
                        n_until = clk_now + PRE_TURN_MS;
                        n_left = base_s; n_right = base_s;
                    end
                end
                PH_PRE: begin
                    n_left = base_s; n_right = base_s;
                    if (expired) begin
                        n_phase = PH_SPIN;
                        n_until = clk_now + SPIN_MS;
                        n_left = spin_l; n_right = spin_r;
                    end
                end
                PH_SPIN, PH_SEEK: begin
                    n_left = spin_l; n_right = spin_r;
                    if (r_phase == PH_SPIN && expired) n_phase = PH_SEEK;
                    if ((r_phase == PH_SEEK || expired) && calm) begin
                        n_prev = 12'sd0;
                        n_phase = PH_NONE;
                        case (r_mode)
                            MD_FWD: begin
                                if (r_fwd == 2'd0) begin
                                    n_rcnt = sat_inc(r_rcnt);
                                    n_stamp = clk_now;
                                    if (n_rcnt >= 2'd2) n_fwd = 2'd1;
                                end else if (r_fwd == 2'd1) begin
                                    n_fwd = 2'd2;
                                end
                            end
                            MD_REV: begin
                                if (r_ret == 2'd0) begin
                                    n_ret = 2'd1;
                                end else if (r_ret == 2'd1) begin
                                    n_lret = sat_inc(r_lret);
                                    n_stamp = clk_now;
                                end
                            end
                            MD_RECOV: n_rec = 1'b1;
                            default: ;
                        endcase
                    end
                end
                PH_DWELL: begin
                    n_left = base_s; n_right = base_s;
                    if (expired) begin
                        n_phase = PH_NONE;
                        if (r_mode == MD_FWD) n_fwd = 2'd3;
                        else if (r_mode == MD_REV) n_ret = 2'd3;
                    end
                end
                default: n_phase = PH_NONE;
            endcase
        end else begin
            if (r_held != FUNC_TICK && r_held <= FUNC_MANUAL)
                n_mode = t_mode'(r_held - 3'd1);
            n_held = FUNC_TICK;
            if (fn_valid) n_mode = t_mode'(i_req.func - 3'd1);
            case (n_mode)
                MD_RESET: begin
                    n_rcnt = 2'd0; n_lfwd = 2'd0; n_lret = 2'd0;
                    n_fwd = 2'd0; n_ret = 2'd0; n_rec = 1'b0;
                    n_hold = clk_now + HOLD_MS;
                    n_phase = PH_NONE;
                    n_mode = MD_IDLE;
                end
                MD_FWD: begin
                    if (!obst && r_fwd != 2'd3) begin
                        n_prev = e; n_left = pd_l; n_right = pd_r;
                        if (r_fwd == 2'd0) begin
                            if (clk_now > r_hold && i_req.right_branch && settled) begin
                                n_spin_r = 1'b1; n_phase = PH_PRE;
                                n_until = clk_now + PRE_TURN_MS;
                                n_left = base_s; n_right = base_s;
                            end
                        end else if (r_fwd == 2'd1) begin
                            if (i_req.left_branch && settled) begin
                                n_lfwd = sat_inc(r_lfwd);
                                n_stamp = clk_now;
                                if (n_lfwd == i_cfg.target_slot) begin
                                    n_spin_r = 1'b0; n_phase = PH_PRE;
                                    n_until = clk_now + PRE_TURN_MS;
                                    n_left = base_s; n_right = base_s;
                                end
                            end
                        end else if (i_req.dest_mark) begin
                            n_phase = PH_DWELL;
                            n_until = clk_now + DWELL_FWD_MS;
                            n_left = base_s; n_right = base_s;
                        end
                    end
                end
                MD_REV: begin
                    if (!obst && r_ret != 2'd3) begin
                        n_prev = e; n_left = pd_l; n_right = pd_r;
                        if (r_ret == 2'd0) begin
                            if (clk_now > r_hold && i_req.cross_mark) begin
                                n_spin_r = 1'b1; n_phase = PH_PRE;
                                n_until = clk_now + PRE_TURN_MS;
                                n_left = base_s; n_right = base_s;
                            end
                        end else if (r_ret == 2'd1) begin
                            if (r_lret < 2'd2) begin
                                if (i_req.left_branch && settled) begin
                                    n_spin_r = 1'b0; n_phase = PH_PRE;
                                    n_until = clk_now + PRE_TURN_MS;
                                    n_left = base_s; n_right = base_s;
                                end
                            end else begin
                                n_ret = 2'd2;
                            end
                        end else if (i_req.dest_mark) begin
                            n_phase = PH_DWELL;
                            n_until = clk_now + DWELL_RET_MS;
                            n_left = base_s; n_right = base_s;
                        end
                    end
                end
                MD_RECOV: begin
                    if (!r_rec) begin
                        n_left  = -$signed({1'b0, i_cfg.back_spd});
                        n_right = -$signed({1'b0, i_cfg.back_spd});
                        if (i_req.cross_mark) begin
                            n_left = 11'sd0; n_right = 11'sd0;
                            n_spin_r = 1'b1; n_phase = PH_PAUSE;
                            n_until = clk_now + PAUSE_MS;
                        end
                    end else begin
                        n_prev = e; n_left = pd_l; n_right = pd_r;
                        if (i_cfg.target_slot != 2'd0) n_lfwd = i_cfg.target_slot - 2'd1;
                        n_stamp = clk_now;
                        n_fwd = 2'd1;
                        n_mode = MD_FWD;
                    end
                end
                MD_MANUAL: begin
                    n_left = man_l; n_right = man_r;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_res.left_speed  = n_left;
        o_res.right_speed = n_right;
        o_res.mode_now    = n_mode;
        o_res.phase_now   = n_phase;
        case (n_mode)
            MD_FWD:   o_res.stage_now = n_fwd;
            MD_REV:   o_res.stage_now = n_ret;
            MD_RECOV: o_res.stage_now = {1'b0, n_rec};
            default:  o_res.stage_now = 2'd0;
        endcase
        o_res.arrived = (n_mode == MD_FWD && n_fwd == 2'd3)
                     || (n_mode == MD_REV && n_ret == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MD_RESET;   r_phase <= PH_NONE;
            r_fwd <= 2'd0;  r_ret <= 2'd0;  r_rec <= 1'b0;
            r_rcnt <= 2'd0; r_lfwd <= 2'd0; r_lret <= 2'd0;
            r_prev <= 12'sd0; r_clock <= 32'd0; r_stamp <= 32'd0;
            r_hold <= HOLD_MS; r_until <= 32'd0;
            r_spin_r <= 1'b0; r_held <= FUNC_TICK;
        end else if (i_adv) begin
            r_mode <= n_mode;   r_phase <= n_phase;
            r_fwd <= n_fwd;  r_ret <= n_ret;  r_rec <= n_rec;
            r_rcnt <= n_rcnt; r_lfwd <= n_lfwd; r_lret <= n_lret;
            r_prev <= n_prev; r_clock <= clk_now; r_stamp <= n_stamp;
            r_hold <= n_hold; r_until <= n_until;
            r_spin_r <= n_spin_r; r_held <= n_held;
        end
    end

endmodule

// ===== design/line_follow_route_controller_top.sv =====
`timescale 1ns / 1ps
// Line-following route controller.
// Control ticks enter on the s_axis request channel: tuser carries the
// mode request (func), tdata the sensor fields. Each accepted tick yields
// exactly one wheel command on m_axis (speeds, mode, stage, phase, arrived).
// Gains, speeds, obstacle threshold and target slot sit on the APB port at
// byte address 4*i; write them only while no tick is in flight.
// Dataflow: a tick is registered on entry, evaluated combinationally against the
// controller state, and registered again in the result register for m_axis.
// Throughput: one tick per cycle unless m_axis stalls; the state update (PD
// multiply, clamp and route bookkeeping) is combinational between the input and
// result registers and is stored with the result, so the next tick sees it at once.
// A stalled receiver holds the result; the input register keeps taking a
// tick until both stages are full, then tready drops.
// Synchronous reset empties both stages, loads the register defaults and
// puts the controller in reset mode with a 2000 ms start hold.
module line_follow_route_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [11:0] line_error, [12] right_branch, [13] left_branch, [14] cross_mark,
    // [15] dest_mark, [28:16] range_tenths, [39:29] manual_left,
    // [50:40] manual_right, [60:51] elapsed_ms, [63:61] zero
    input  logic [63:0] i_s_axis_tdata,
    // [2:0] func
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [10:0] left_speed, [21:11] right_speed, [24:22] mode_now,
    // [26:25] stage_now, [29:27] phase_now, [30] arrived, [31] zero
    output logic [31:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfrc_pkg::*;

    t_cfg cfg;
    t_req r_req;
    t_res res, r_res;
    logic r_in_vld, r_out_vld, adv;

    assign adv             = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || adv;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_res.arrived, r_res.phase_now, r_res.stage_now,
                              r_res.mode_now, r_res.right_speed, r_res.left_speed};

    lfrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfrc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (cfg),
        .i_req   (r_req),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_req.func         <= i_s_axis_tuser;
            r_req.line_error   <= i_s_axis_tdata[11:0];
            r_req.right_branch <= i_s_axis_tdata[12];
            r_req.left_branch  <= i_s_axis_tdata[13];
            r_req.cross_mark   <= i_s_axis_tdata[14];
            r_req.dest_mark    <= i_s_axis_tdata[15];
            r_req.range_tenths <= i_s_axis_tdata[28:16];
            r_req.manual_left  <= i_s_axis_tdata[39:29];
            r_req.manual_right <= i_s_axis_tdata[50:40];
            r_req.elapsed_ms   <= i_s_axis_tdata[60:51];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_res <= res;
    end

    a_no_reset_mode_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[24:22] != MD_RESET)
        else $error("result shows reset mode");

    a_arrived_no_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[30]) |-> o_m_axis_tdata[29:27] == PH_NONE)
        else $error("arrived with a phase active");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

// ===== sim/line_follow_route_controller_top_test.sv =====
`timescale 1ns / 1ps
module line_follow_route_controller_top_test;
    import lfrc_pkg::*;

    localparam logic [2:0] FN_RESET = 3'd1;
    localparam logic [2:0] FN_IDLE  = 3'd2;
    localparam logic [2:0] FN_FWD   = 3'd3;
    localparam logic [2:0] FN_REV   = 3'd4;
    localparam logic [2:0] FN_REC   = 3'd5;
    localparam logic [2:0] FN_BAD   = 3'd7;
    localparam int STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;
    logic [2:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    line_follow_route_controller_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // controller settings mirror
    logic [15:0] k_prop, k_deriv;
    logic [9:0]  spd_base, spd_max, spd_turn, spd_rev;
    logic [12:0] obst_lim;
    logic [1:0]  tgt_slot;

    // controller state mirror
    t_mode       ctl_mode;
    t_phase      ctl_phase;
    logic [1:0]  fwd_stg, ret_stg, right_cnt, left_cnt_fwd, left_cnt_ret;
    logic        rec_stg, spin_cw;
    logic [2:0]  held_func;
    int          last_err;
    logic [31:0] now_ms, branch_ms, hold_until_ms, phase_end_ms;
    int          wheel_l, wheel_r;

    t_res        cmd_q[$];
    t_res        want_res;
    int          n_sent, n_checked, n_err, idle_cnt;
    bit          tx_idle_en, rx_idle_en;
    int          rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic ctl_reset();
        k_prop = 16'd256; k_deriv = 16'd0; spd_base = 10'd150; spd_max = 10'd255;
        spd_turn = 10'd120; spd_rev = 10'd100; obst_lim = 13'd150; tgt_slot = 2'd1;
        ctl_mode = MD_RESET; ctl_phase = PH_NONE;
        fwd_stg = 0; ret_stg = 0; rec_stg = 0;
        right_cnt = 0; left_cnt_fwd = 0; left_cnt_ret = 0;
        last_err = 0; now_ms = 0; branch_ms = 0; hold_until_ms = HOLD_MS;
        phase_end_ms = 0; spin_cw = 0; held_func = 0;
        wheel_l = 0; wheel_r = 0;
    endtask

    function automatic bit phase_done();
        logic [31:0] d;
        d = now_ms - phase_end_ms;
        return d < 32'h8000_0000;
    endfunction

    function automatic logic [1:0] bump(logic [1:0] c);
        return (c < 2'd3) ? c + 2'd1 : 2'd3;
    endfunction

    task automatic set_wheels(int l, int r);
        wheel_l = l;
        wheel_r = r;
    endtask

    task automatic pd_steer(int e);
        longint acc, u, l, r;
        acc = longint'(e) * longint'(k_prop) + longint'(e - last_err) * longint'(k_deriv);
        u = acc / 65536;
        l = longint'(spd_base) + u;
        r = longint'(spd_base) - u;
        if (l > longint'(spd_max)) l = spd_max;
        if (l < 0) l = 0;
        if (r > longint'(spd_max)) r = spd_max;
        if (r < 0) r = 0;
        last_err = e;
        set_wheels(int'(l), int'(r));
    endtask

    task automatic spin_wheels();
        if (spin_cw) set_wheels(int'(spd_turn), -int'(spd_turn));
        else set_wheels(-int'(spd_turn), int'(spd_turn));
    endtask

    task automatic begin_turn(logic cw);
        spin_cw = cw;
        ctl_phase = PH_PRE;
        phase_end_ms = now_ms + PRE_TURN_MS;
        set_wheels(int'(spd_base), int'(spd_base));
    endtask

    task automatic begin_dwell(logic [31:0] ms);
        ctl_phase = PH_DWELL;
        phase_end_ms = now_ms + ms;
        set_wheels(int'(spd_base), int'(spd_base));
    endtask

    task automatic end_turn();
        last_err = 0;
        ctl_phase = PH_NONE;
        if (ctl_mode == MD_FWD) begin
            if (fwd_stg == 0) begin
                right_cnt = bump(right_cnt);
                branch_ms = now_ms;
                if (right_cnt >= 2) fwd_stg = 1;
            end else if (fwd_stg == 1) begin
                fwd_stg = 2;
            end
        end else if (ctl_mode == MD_REV) begin
            if (ret_stg == 0) begin
                ret_stg = 1;
            end else if (ret_stg == 1) begin
                left_cnt_ret = bump(left_cnt_ret);
                branch_ms = now_ms;
            end
        end else if (ctl_mode == MD_RECOV) begin
            rec_stg = 1;
        end
    endtask

    task automatic step_phase(int e);
        int ae;
        ae = (e < 0) ? -e : e;
        case (ctl_phase)
            PH_PAUSE: begin
                set_wheels(0, 0);
                if (phase_done()) begin_turn(spin_cw);
            end
            PH_PRE: begin
                set_wheels(int'(spd_base), int'(spd_base));
                if (phase_done()) begin
                    ctl_phase = PH_SPIN;
                    phase_end_ms = now_ms + SPIN_MS;
                    spin_wheels();
                end
            end
            PH_SPIN: begin
                spin_wheels();
                if (phase_done()) begin
                    ctl_phase = PH_SEEK;
                    if (ae <= 51) end_turn();
                end
            end
            PH_SEEK: begin
                spin_wheels();
                if (ae <= 51) end_turn();
            end
            PH_DWELL: begin
                set_wheels(int'(spd_base), int'(spd_base));
                if (phase_done()) begin
                    ctl_phase = PH_NONE;
                    if (ctl_mode == MD_FWD) fwd_stg = 3;
                    else if (ctl_mode == MD_REV) ret_stg = 3;
                end
            end
            default: begin
                ctl_phase = PH_NONE;
                set_wheels(0, 0);
            end
        endcase
    endtask

    task automatic step_mode(t_req r, int e);
        bit obst, settled;
        int ml, mr;
        obst = r.range_tenths > NEAR_LIMIT && r.range_tenths < obst_lim;
        settled = (now_ms - branch_ms) > DEBOUNCE_MS;
        set_wheels(0, 0);
        case (ctl_mode)
            MD_RESET: begin
                right_cnt = 0; left_cnt_fwd = 0; left_cnt_ret = 0;
                fwd_stg = 0; ret_stg = 0; rec_stg = 0;
                hold_until_ms = now_ms + HOLD_MS;
                ctl_phase = PH_NONE;
                ctl_mode = MD_IDLE;
            end
            MD_FWD: if (!obst) begin
                if (fwd_stg == 0) begin
                    pd_steer(e);
                    if (now_ms > hold_until_ms && r.right_branch && settled) begin_turn(1'b1);
                end else if (fwd_stg == 1) begin
                    pd_steer(e);
                    if (r.left_branch && settled) begin
                        left_cnt_fwd = bump(left_cnt_fwd);
                        branch_ms = now_ms;
                        if (left_cnt_fwd == tgt_slot) begin_turn(1'b0);
                    end
                end else if (fwd_stg == 2) begin
                    pd_steer(e);
                    if (r.dest_mark) begin_dwell(DWELL_FWD_MS);
                end
            end
            MD_REV: if (!obst) begin
                if (ret_stg == 0) begin
                    pd_steer(e);
                    if (now_ms > hold_until_ms && r.cross_mark) begin_turn(1'b1);
                end else if (ret_stg == 1) begin
                    pd_steer(e);
                    if (left_cnt_ret < 2) begin
                        if (r.left_branch && settled) begin_turn(1'b0);
                    end else begin
                        ret_stg = 2;
                    end
                end else if (ret_stg == 2) begin
                    pd_steer(e);
                    if (r.dest_mark) begin_dwell(DWELL_RET_MS);
                end
            end
            MD_RECOV: begin
                if (rec_stg == 0) begin
                    set_wheels(-int'(spd_rev), -int'(spd_rev));
                    if (r.cross_mark) begin
                        set_wheels(0, 0);
                        spin_cw = 1;
                        ctl_phase = PH_PAUSE;
                        phase_end_ms = now_ms + PAUSE_MS;
                    end
                end else begin
                    pd_steer(e);
                    if (tgt_slot >= 1) left_cnt_fwd = tgt_slot - 2'd1;
                    branch_ms = now_ms;
                    fwd_stg = 1;
                    ctl_mode = MD_FWD;
                end
            end
            MD_MANUAL: begin
                ml = $signed(r.manual_left);
                mr = $signed(r.manual_right);
                if (ml < -1023) ml = -1023;
                if (mr < -1023) mr = -1023;
                set_wheels(ml, mr);
            end
            default: ;
        endcase
    endtask

    task automatic ctl_tick(t_req r, output t_res o);
        int e;
        logic [1:0] stg;
        e = $signed(r.line_error);
        stg = 0;
        now_ms = now_ms + r.elapsed_ms;
        if (ctl_phase != PH_NONE) begin
            if (r.func >= 1 && r.func <= 6) held_func = r.func;
            step_phase(e);
        end else begin
            if (held_func >= 1 && held_func <= 6) ctl_mode = t_mode'(held_func - 3'd1);
            held_func = 0;
            if (r.func >= 1 && r.func <= 6) ctl_mode = t_mode'(r.func - 3'd1);
            step_mode(r, e);
        end
        if (ctl_mode == MD_FWD) stg = fwd_stg;
        else if (ctl_mode == MD_REV) stg = ret_stg;
        else if (ctl_mode == MD_RECOV) stg = {1'b0, rec_stg};
        o.left_speed = wheel_l[10:0];
        o.right_speed = wheel_r[10:0];
        o.mode_now = ctl_mode;
        o.stage_now = stg;
        o.phase_now = ctl_phase;
        o.arrived = (ctl_mode == MD_FWD && fwd_stg == 3) ||
                    (ctl_mode == MD_REV && ret_stg == 3);
    endtask

    task automatic send_tick(t_req r);
        t_res o;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= r.func;
        i_s_axis_tdata <= {3'b0, r.elapsed_ms, r.manual_right, r.manual_left,
                           r.range_tenths, r.dest_mark, r.cross_mark, r.left_branch,
                           r.right_branch, r.line_error};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ctl_tick(r, o);
        cmd_q.push_back(o);
        n_sent++;
        if (tx_idle_en && $urandom_range(5, 0) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        case (idx)
            REG_PROP:    k_prop = v[15:0];
            REG_DERIV:   k_deriv = v[15:0];
            REG_BASE:    spd_base = v[9:0];
            REG_MAX:     spd_max = v[9:0];
            REG_TURN:    spd_turn = v[9:0];
            REG_REVERSE: spd_rev = v[9:0];
            REG_OBST:    obst_lim = v[12:0];
            REG_TARGET:  tgt_slot = v[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic cfg_all(logic [31:0] p, d, b, m, t, rv, ob, tg);
        wait_drained();
        cfg_write(REG_PROP, p);
        cfg_write(REG_DERIV, d);
        cfg_write(REG_BASE, b);
        cfg_write(REG_MAX, m);
        cfg_write(REG_TURN, t);
        cfg_write(REG_REVERSE, rv);
        cfg_write(REG_OBST, ob);
        cfg_write(REG_TARGET, tg);
    endtask

    function automatic t_req mk_tick(logic [2:0] fn, int e, int rng, int ms);
        t_req r;
        r = '0;
        r.func = fn;
        r.line_error = e[11:0];
        r.range_tenths = rng[12:0];
        r.elapsed_ms = ms[9:0];
        return r;
    endfunction

    function automatic t_req noise_tick();
        t_req r;
        r = {$urandom, $urandom};
        r.func = 3'($urandom_range(7, 0));
        r.line_error = 12'($urandom);
        r.range_tenths = 13'($urandom);
        r.manual_left = 11'($urandom);
        r.manual_right = 11'($urandom);
        r.elapsed_ms = 10'($urandom);
        return r;
    endfunction

    function automatic t_req route_tick();
        t_req r;
        int v;
        r = noise_tick();
        r.func = ($urandom_range(99, 0) < 3) ? 3'($urandom_range(7, 1)) : FUNC_TICK;
        if ($urandom_range(9, 0) < 7) begin
            v = int'($urandom_range(120, 0)) - 60;
            r.line_error = v[11:0];
        end
        r.right_branch = $urandom_range(99, 0) < 25;
        r.left_branch = $urandom_range(99, 0) < 25;
        r.cross_mark = $urandom_range(99, 0) < 20;
        r.dest_mark = $urandom_range(99, 0) < 20;
        if ($urandom_range(9, 0) != 0) r.range_tenths = 13'($urandom_range(8191, obst_lim));
        if ($urandom_range(4, 0) != 0) r.elapsed_ms = 10'($urandom_range(300, 20));
        return r;
    endfunction

    task automatic run_route(logic [2:0] fn, int n);
        t_req r;
        r = route_tick();
        r.func = fn;
        send_tick(r);
        repeat (n) begin
            if ($urandom_range(99, 0) < 12) send_tick(noise_tick());
            else send_tick(route_tick());
        end
    endtask

    task automatic test_directed();
        t_req r;
        send_tick(mk_tick(FN_RESET, 0, 1000, 10));
        send_tick(mk_tick(FN_IDLE, 0, 1000, 10));
        r = mk_tick(FUNC_MANUAL, 0, 1000, 10);
        r.manual_left = 11'sd1023; r.manual_right = 11'h400;
        send_tick(r);
        r.manual_left = 11'h400; r.manual_right = -11'sd1023;
        send_tick(r);
        send_tick(mk_tick(FN_BAD, 0, 1000, 0));
        send_tick(mk_tick(FN_FWD, 2047, 0, 1023));
        send_tick(mk_tick(FUNC_TICK, -2048, 8191, 0));
        send_tick(mk_tick(FUNC_TICK, 100, 21, 5));
        r = mk_tick(FUNC_TICK, 0, 20, 5); r.right_branch = 1;
        send_tick(r);
        r.elapsed_ms = 10'd1023;
        send_tick(r);
        send_tick(mk_tick(FUNC_MANUAL, 0, 1000, 1023));
        send_tick(mk_tick(FUNC_TICK, 2047, 1000, 1023));
        send_tick(mk_tick(FUNC_TICK, -51, 1000, 10));
        send_tick(mk_tick(FUNC_TICK, 0, 1000, 10));
        send_tick(mk_tick(FN_REC, 0, 1000, 10));
        r = mk_tick(FUNC_TICK, 0, 1000, 10); r.cross_mark = 1;
        send_tick(r);
        send_tick(mk_tick(FN_REV, 0, 1000, 300));
        repeat (3) send_tick(mk_tick(FUNC_TICK, 52, 1000, 400));
        send_tick(mk_tick(FUNC_TICK, 51, 1000, 10));
        send_tick(mk_tick(FUNC_TICK, 30, 1000, 10));
        r = mk_tick(FN_REV, 0, 1000, 10); r.dest_mark = 1;
        send_tick(r);
    endtask

    task automatic test_forward_routes();
        repeat (6) begin
            run_route(FN_RESET, 0);
            run_route(FN_FWD, 60);
        end
    endtask

    task automatic test_return_routes();
        repeat (6) begin
            run_route(FN_RESET, 0);
            run_route(FN_REV, 60);
        end
    endtask

    task automatic test_recovery();
        repeat (5) begin
            run_route(FN_REC, 30);
            run_route(FUNC_MANUAL, 8);
        end
    endtask

    task automatic mixed_routes();
        run_route(FN_RESET, 0);
        run_route(FN_FWD, 30);
        run_route(FN_REV, 30);
        run_route(FN_REC, 25);
        run_route(FUNC_MANUAL, 10);
    endtask

    task automatic test_config_sweep();
        cfg_all(65535, 65535, 1023, 1023, 1023, 1023, 8191, 3);
        mixed_routes();
        cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
        mixed_routes();
        cfg_all($urandom_range(2048, 256), $urandom_range(65535, 0),
                $urandom_range(300, 100), $urandom_range(1023, 255),
                $urandom_range(400, 60), $urandom_range(300, 50),
                $urandom_range(400, 100), $urandom_range(3, 1));
        mixed_routes();
        cfg_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
        mixed_routes();
        cfg_all(256, 0, 150, 255, 120, 100, 150, 1);
        mixed_routes();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 0;
        rx_hold = 300;
        run_route(FN_FWD, 40);
        wait_drained();
        tx_idle_en = 1;
        run_route(FN_REV, 20);
    endtask

    task automatic test_full_rate();
        tx_idle_en = 0;
        rx_idle_en = 0;
        run_route(FN_RESET, 0);
        run_route(FN_FWD, 80);
        run_route(FN_REV, 80);
        run_route(FN_REC, 40);
    endtask

    task automatic check_field(string nm, int want, int got);
        if (want != got) begin
            n_err++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (cmd_q.size() == 0) begin
                n_err++;
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, o_m_axis_tdata);
            end else begin
                want_res = cmd_q.pop_front();
                check_field("left_speed", want_res.left_speed, $signed(o_m_axis_tdata[10:0]));
                check_field("right_speed", want_res.right_speed,
                            $signed(o_m_axis_tdata[21:11]));
                check_field("mode_now", want_res.mode_now, o_m_axis_tdata[24:22]);
                check_field("stage_now", want_res.stage_now, o_m_axis_tdata[26:25]);
                check_field("phase_now", want_res.phase_now, o_m_axis_tdata[29:27]);
                check_field("arrived", want_res.arrived, o_m_axis_tdata[30]);
                n_checked++;
            end
        end
    end

    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                n = rx_hold;
                rx_hold = 0;
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(4, 0) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(14, 1)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        n_sent = 0; n_checked = 0; n_err = 0;
        tx_idle_en = 1; rx_idle_en = 1; rx_hold = 0;
        ctl_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_forward_routes();
        test_return_routes();
        test_recovery();
        test_config_sweep();
        test_backpressure();
        test_full_rate();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d control ticks, checked %0d wheel commands, %0d mismatches.",
                 n_sent, n_checked, n_err);
        $display("Covered forward/return routes, recovery, manual, obstacles, settings sweep.");
        if (n_err == 0 && cmd_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
